[rtl/core/bbps_pkg.sv]
package bbps_pkg;

  localparam logic [10:0] MAX_RANKS = 11'd1024;
  localparam logic [11:0] NEGA_MASK = 12'hAAA;

  typedef enum logic [2:0] {
    ACT_SEND    = 3'd0,
    ACT_RECV    = 3'd1,
    ACT_WAIT    = 3'd2,
    ACT_XSEND   = 3'd3,
    ACT_XRECV   = 3'd4,
    ACT_NOTHING = 3'd5,
    ACT_INVALID = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TREE,
    ST_WAIT,
    ST_EXTRA
  } state_t;

endpackage

[rtl/core/bbps_req_if.sv]
interface bbps_req_if;
  logic        valid;
  logic        ready;
  logic [9:0]  own_rank;
  logic [9:0]  root_rank;
  logic [10:0] group_size;
  logic        message_empty;

  modport source (
    output valid, own_rank, root_rank, group_size, message_empty,
    input  ready
  );
  modport sink (
    input  valid, own_rank, root_rank, group_size, message_empty,
    output ready
  );
endinterface

[rtl/core/bbps_act_if.sv]
interface bbps_act_if;
  logic              valid;
  logic              ready;
  bbps_pkg::action_t action;
  logic [9:0]        partner_rank;
  logic              last;

  modport source (
    output valid, action, partner_rank, last,
    input  ready
  );
  modport sink (
    input  valid, action, partner_rank, last,
    output ready
  );
endinterface

[rtl/core/bine_broadcast_partner_schedule.sv]
// Bine tree broadcast schedule generator. Each request (own rank, root, group
// size, empty flag) is latched, checked in the check state, and then answered
// with one action beat per cycle, while the output is not stalled, through a
// registered output: log2(P) tree steps for virtual ranks below P (P the
// largest power of two not above the group size), a wait, and an optional
// extra-rank send or receive, the last beat flagged by last. The input is
// ready again the cycle after the final beat is loaded, and invalid or trivial
// requests load their single beat from the check state. Every partner rank
// comes from one shared adder with a conditional subtract of the group size,
// used at most once per emitted beat. A new request is taken only once the
// previous schedule has been fully loaded into the output register; stalls
// on the result side hold the sequencer.
module bine_broadcast_partner_schedule (
  input  logic       clk,
  input  logic       rst_n,
  bbps_req_if.sink   in_req,
  bbps_act_if.source out_act
);
  import bbps_pkg::*;

  state_t      state_r, state_nxt;

  logic [9:0]  me_r, root_r;
  logic [10:0] gs_r;
  logic        empty_r;

  logic [10:0] pow2_r, pow2_nxt;
  logic [9:0]  vrank_r, vrank_nxt;
  logic [11:0] nega_r, nega_nxt;
  logic [9:0]  step_mask_r, step_mask_nxt;
  logic        holds_r, holds_nxt;

  logic        out_valid_r;
  action_t     out_action_r;
  logic [9:0]  out_partner_r;
  logic        out_last_r;

  logic        in_fire, slot_free;
  logic        emit;
  action_t     emit_action;
  logic [9:0]  emit_partner;
  logic        emit_last;

  logic        bad_req, trivial_req;
  logic [10:0] pow2_calc;
  logic [10:0] vrank_calc;
  logic [11:0] nega_calc;
  logic        ext_down, ext_up, has_extra;

  logic [10:0] low_mask;
  logic [11:0] flipped, bin;
  logic [10:0] lsbs;
  logic        recv_ok;

  // shared partner unit: (opnd + root) mod group size, opnd < group size
  logic [10:0] opnd;
  logic [11:0] psum, pred;
  logic [9:0]  partner;

  assign in_fire   = in_req.valid && in_req.ready;
  assign slot_free = !out_valid_r || out_act.ready;

  assign in_req.ready         = (state_r == ST_IDLE);
  assign out_act.valid        = out_valid_r;
  assign out_act.action       = out_action_r;
  assign out_act.partner_rank = out_partner_r;
  assign out_act.last         = out_last_r;

  assign bad_req = (gs_r == 11'd0) || (gs_r > MAX_RANKS) ||
                   ({1'b0, me_r} >= gs_r) || ({1'b0, root_r} >= gs_r);
  assign trivial_req = (gs_r == 11'd1) || empty_r;

  always_comb begin
    pow2_calc = 11'd1;
    for (int i = 0; i < 11; i++) begin
      if (gs_r[i]) pow2_calc = 11'd1 << i;
    end
  end

  assign vrank_calc = {1'b0, me_r} + ((me_r >= root_r) ? 11'd0 : gs_r) - {1'b0, root_r};
  assign nega_calc  = ({1'b0, vrank_calc} + NEGA_MASK) ^ NEGA_MASK;

  assign ext_down  = ({1'b0, vrank_r} >= pow2_r);
  assign ext_up    = ({1'b0, vrank_r} < (gs_r - pow2_r));
  assign has_extra = ext_down || ext_up;

  assign low_mask = ({1'b0, step_mask_r} << 1) - 11'd1;
  assign flipped  = nega_r ^ {1'b0, low_mask};
  assign bin      = (flipped ^ NEGA_MASK) - NEGA_MASK;
  assign lsbs     = nega_r[10:0] & low_mask;
  assign recv_ok  = (lsbs == 11'd0) || (lsbs == low_mask);

  always_comb begin
    if (state_r == ST_EXTRA) begin
      opnd = ext_down ? ({1'b0, vrank_r} - pow2_r) : (pow2_r + {1'b0, vrank_r});
    end else begin
      opnd = bin[10:0] & (pow2_r - 11'd1);
    end
  end

  assign psum    = {1'b0, opnd} + {2'b00, root_r};
  assign pred    = (psum >= {1'b0, gs_r}) ? (psum - {1'b0, gs_r}) : psum;
  assign partner = pred[9:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (bad_req || trivial_req) begin
          if (slot_free) state_nxt = ST_IDLE;
        end else begin
          state_nxt = (vrank_calc < pow2_calc) ? ST_TREE : ST_WAIT;
        end
      end
      ST_TREE: begin
        if (slot_free && step_mask_r == 10'd1) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (slot_free) state_nxt = has_extra ? ST_EXTRA : ST_IDLE;
      end
      ST_EXTRA: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // beat generation and datapath updates
  always_comb begin
    emit          = 1'b0;
    emit_action   = ACT_NOTHING;
    emit_partner  = 10'd0;
    emit_last     = 1'b0;
    pow2_nxt      = pow2_r;
    vrank_nxt     = vrank_r;
    nega_nxt      = nega_r;
    step_mask_nxt = step_mask_r;
    holds_nxt     = holds_r;
    unique case (state_r)
      ST_IDLE: ;
      ST_CHECK: begin
        if (bad_req) begin
          emit        = slot_free;
          emit_action = ACT_INVALID;
          emit_last   = 1'b1;
        end else if (trivial_req) begin
          emit        = slot_free;
          emit_action = ACT_NOTHING;
          emit_last   = 1'b1;
        end else begin
          pow2_nxt      = pow2_calc;
          vrank_nxt     = vrank_calc[9:0];
          nega_nxt      = nega_calc;
          step_mask_nxt = pow2_calc[10:1];
          holds_nxt     = (me_r == root_r);
        end
      end
      ST_TREE: begin
        emit = slot_free;
        if (holds_r) begin
          emit_action  = ACT_SEND;
          emit_partner = partner;
        end else if (recv_ok) begin
          emit_action  = ACT_RECV;
          emit_partner = partner;
          if (slot_free) holds_nxt = 1'b1;
        end
        if (slot_free) step_mask_nxt = step_mask_r >> 1;
      end
      ST_WAIT: begin
        emit        = slot_free;
        emit_action = ACT_WAIT;
        emit_last   = !has_extra;
      end
      ST_EXTRA: begin
        emit         = slot_free;
        emit_action  = ext_down ? ACT_XRECV : ACT_XSEND;
        emit_partner = partner;
        emit_last    = 1'b1;
        if (slot_free && ext_down) holds_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_mask_r <= '0;
      holds_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_mask_r <= step_mask_nxt;
      holds_r     <= holds_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_act.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      me_r    <= in_req.own_rank;
      root_r  <= in_req.root_rank;
      gs_r    <= in_req.group_size;
      empty_r <= in_req.message_empty;
    end
    pow2_r  <= pow2_nxt;
    vrank_r <= vrank_nxt;
    nega_r  <= nega_nxt;
    if (emit) begin
      out_action_r  <= emit_action;
      out_partner_r <= emit_partner;
      out_last_r    <= emit_last;
    end
  end

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (state_r == ST_IDLE))
    else $error("final beat loaded but sequencer not idle");

  a_tree_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TREE) |-> $onehot(step_mask_r))
    else $error("tree step mask not one-hot");

  a_no_peer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_action_r == ACT_WAIT || out_action_r == ACT_NOTHING ||
                     out_action_r == ACT_INVALID)) |-> (out_partner_r == 10'd0))
    else $error("nonzero partner on a peerless action");

  a_tree_actions: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TREE && emit) |->
      (emit_action == ACT_SEND || emit_action == ACT_RECV || emit_action == ACT_NOTHING))
    else $error("tree step produced a non-tree action");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
  import bbps_pkg::*;

  typedef struct packed {
    logic [9:0]  own;
    logic [9:0]  root;
    logic [10:0] size;
    logic        empty;
  } req_t;

  typedef struct packed {
    action_t     act;
    logic [9:0]  partner;
    logic        last;
  } beat_t;

  // fixed: the single beat of an invalid or trivial request is written in
  typedef struct packed {
    req_t        req;
    logic        fixed;
    action_t     act;
  } row_t;

  logic clk;
  logic rst_n;

  bbps_req_if in_req();
  bbps_act_if out_act();

  bine_broadcast_partner_schedule u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_act (out_act)
  );

  beat_t       sched_q[$];
  row_t        plan[$];
  beat_t       mon_want;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          err_cnt;
  int          n_req;
  int          n_beats;
  int          act_seen[7];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    out_act.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Outputs are stable at the falling edge; a beat seen here is taken at the next rise.
  always @(negedge clk) begin
    if (rst_n && out_act.valid && out_act.ready) begin
      n_beats++;
      if (out_act.action <= ACT_INVALID) act_seen[out_act.action]++;
      if (sched_q.size() == 0) begin
        $error("unexpected action beat: action %0d partner %0d last %0d",
               out_act.action, out_act.partner_rank, out_act.last);
        err_cnt++;
      end else begin
        mon_want = sched_q.pop_front();
        if (out_act.action !== mon_want.act) begin
          $error("action: expected %0d, got %0d", mon_want.act, out_act.action);
          err_cnt++;
        end
        if (out_act.partner_rank !== mon_want.partner) begin
          $error("partner_rank: expected %0d, got %0d", mon_want.partner,
                 out_act.partner_rank);
          err_cnt++;
        end
        if (out_act.last !== mon_want.last) begin
          $error("last: expected %0d, got %0d", mon_want.last, out_act.last);
          err_cnt++;
        end
      end
    end
  end

  function automatic void push_sched(input action_t acts[$], input int parts[$]);
    beat_t b;
    for (int i = 0; i < acts.size(); i++) begin
      b.act     = acts[i];
      b.partner = 10'(parts[i]);
      b.last    = (i == acts.size() - 1);
      sched_q.push_back(b);
    end
  endfunction

  function automatic void predict_schedule(input req_t r);
    action_t     acts[$];
    int          parts[$];
    int          own_i;
    int          root_i;
    int          size_i;
    int          p2;
    int          vr;
    int          step;
    int          partner;
    logic        held;
    logic [11:0] vr12;
    logic [11:0] nb;
    logic [11:0] low;
    logic [11:0] bin;
    logic [11:0] lsbs;
    own_i  = r.own;
    root_i = r.root;
    size_i = r.size;
    if (size_i == 0 || size_i > MAX_RANKS || own_i >= size_i || root_i >= size_i) begin
      acts.push_back(ACT_INVALID);
      parts.push_back(0);
    end else if (size_i == 1 || r.empty) begin
      acts.push_back(ACT_NOTHING);
      parts.push_back(0);
    end else begin
      p2 = 1;
      while (p2 * 2 <= size_i) p2 = p2 * 2;
      vr   = (own_i >= root_i) ? own_i - root_i : own_i + size_i - root_i;
      held = (own_i == root_i);
      vr12 = 12'(vr);
      nb   = (vr12 + NEGA_MASK) ^ NEGA_MASK;
      if (vr < p2) begin
        for (step = p2 / 2; step != 0; step = step / 2) begin
          low     = 12'(step * 2 - 1);
          // flip the low bits in negabinary, then return to binary
          bin     = ((nb ^ low) ^ NEGA_MASK) - NEGA_MASK;
          partner = (bin & (p2 - 1)) + root_i;
          if (partner >= size_i) partner -= size_i;
          lsbs = nb & low;
          if (held) begin
            acts.push_back(ACT_SEND);
            parts.push_back(partner);
          end else if (lsbs == 12'd0 || lsbs == low) begin
            acts.push_back(ACT_RECV);
            parts.push_back(partner);
            held = 1'b1;
          end else begin
            acts.push_back(ACT_NOTHING);
            parts.push_back(0);
          end
        end
      end
      acts.push_back(ACT_WAIT);
      parts.push_back(0);
      if (vr >= p2) begin
        partner = vr - p2 + root_i;
        if (partner >= size_i) partner -= size_i;
        acts.push_back(ACT_XRECV);
        parts.push_back(partner);
      end else if (vr < size_i - p2) begin
        partner = p2 + vr + root_i;
        if (partner >= size_i) partner -= size_i;
        acts.push_back(ACT_XSEND);
        parts.push_back(partner);
      end
    end
    push_sched(acts, parts);
  endfunction

  function automatic row_t mk_row(input int own, input int root, input int size,
                                  input bit empty, input bit fixed, input action_t act);
    row_t w;
    w.req.own   = 10'(own);
    w.req.root  = 10'(root);
    w.req.size  = 11'(size);
    w.req.empty = empty;
    w.fixed     = fixed;
    w.act       = act;
    return w;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int   sel;
    int   sz;
    int   c;
    sel     = $urandom_range(99);
    r.own   = 10'($urandom_range(1023));
    r.root  = 10'($urandom_range(1023));
    r.empty = 1'($urandom_range(1));
    if (sel < 5) begin
      sz = $urandom_range(1) ? 0 : $urandom_range(2047, 1025);
    end else if (sel < 10) begin
      sz     = 1;
      r.own  = 10'd0;
      r.root = 10'd0;
    end else if (sel < 20) begin
      // at least one rank outside the group
      sz = $urandom_range(1023, 1);
      if ($urandom_range(1)) r.own = 10'($urandom_range(1023, sz));
      else r.root = 10'($urandom_range(1023, sz));
    end else begin
      c = $urandom_range(9);
      if (c < 4) sz = $urandom_range(16, 2);
      else if (c == 9) sz = 1024;
      else sz = $urandom_range(1024, 2);
      r.own   = 10'($urandom_range(sz - 1));
      r.root  = 10'($urandom_range(sz - 1));
      r.empty = ($urandom_range(19) == 0);
    end
    r.size = 11'(sz);
    return r;
  endfunction

  task automatic drive_req(input req_t r, input bit fixed, input action_t act);
    beat_t b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid         <= 1'b1;
    in_req.own_rank      <= r.own;
    in_req.root_rank     <= r.root;
    in_req.group_size    <= r.size;
    in_req.message_empty <= r.empty;
    @(negedge clk);
    while (!in_req.ready) @(negedge clk);
    if (fixed) begin
      b.act     = act;
      b.partner = '0;
      b.last    = 1'b1;
      sched_q.push_back(b);
    end else begin
      predict_schedule(r);
    end
    n_req++;
    @(posedge clk);
  endtask

  initial begin
    int          guard;
    int unsigned idle_pct[4];
    int unsigned stall_pct[4];
    idle_pct  = '{0, 64, 0, 20};
    stall_pct = '{0, 0, 64, 20};
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_req.valid         = 1'b0;
    in_req.own_rank      = '0;
    in_req.root_rank     = '0;
    in_req.group_size    = '0;
    in_req.message_empty = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    err_cnt              = 0;
    n_req                = 0;
    n_beats              = 0;
    foreach (act_seen[i]) act_seen[i] = 0;

    //                  own   root  size  empty fixed act
    plan.push_back(mk_row(0,    0,    0,    0, 1, ACT_INVALID));
    plan.push_back(mk_row(0,    0,    1025, 0, 1, ACT_INVALID));
    plan.push_back(mk_row(1023, 1023, 2047, 1, 1, ACT_INVALID));
    plan.push_back(mk_row(5,    0,    5,    0, 1, ACT_INVALID));
    plan.push_back(mk_row(0,    1023, 1023, 0, 1, ACT_INVALID));
    plan.push_back(mk_row(1023, 0,    1023, 1, 1, ACT_INVALID));
    plan.push_back(mk_row(0,    0,    1,    0, 1, ACT_NOTHING));
    plan.push_back(mk_row(0,    0,    1,    1, 1, ACT_NOTHING));
    plan.push_back(mk_row(1023, 0,    1024, 1, 1, ACT_NOTHING));
    plan.push_back(mk_row(0,    0,    1024, 0, 0, ACT_NOTHING));
    plan.push_back(mk_row(1023, 1023, 1024, 0, 0, ACT_NOTHING));
    plan.push_back(mk_row(1023, 0,    1024, 0, 0, ACT_NOTHING));
    plan.push_back(mk_row(0,    1023, 1024, 0, 0, ACT_NOTHING));
    plan.push_back(mk_row(1022, 0,    1023, 0, 0, ACT_NOTHING));
    plan.push_back(mk_row(0,    0,    1023, 0, 0, ACT_NOTHING));
    plan.push_back(mk_row(1,    0,    2,    0, 0, ACT_NOTHING));
    plan.push_back(mk_row(0,    1,    2,    0, 0, ACT_NOTHING));
    plan.push_back(mk_row(2,    0,    3,    0, 0, ACT_NOTHING));
    plan.push_back(mk_row(0,    1,    3,    0, 0, ACT_NOTHING));
    plan.push_back(mk_row(999,  500,  1000, 0, 0, ACT_NOTHING));
    plan.push_back(mk_row(512,  512,  513,  0, 0, ACT_NOTHING));
    plan.push_back(mk_row(3,    5,    6,    0, 0, ACT_NOTHING));
    plan.push_back(mk_row(682,  0,    1024, 0, 0, ACT_NOTHING));
    plan.push_back(mk_row(341,  0,    1024, 0, 0, ACT_NOTHING));
    plan.push_back(mk_row(511,  1,    512,  0, 0, ACT_NOTHING));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) drive_req(plan[i].req, plan[i].fixed, plan[i].act);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_pct[ph];
      recv_stall_pct = stall_pct[ph];
      repeat (89) drive_req(rand_req(), 1'b0, ACT_NOTHING);
    end

    // drain
    in_req.valid   <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (guard = 0; sched_q.size() != 0 && guard < 5000; guard++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sched_q.size() != 0) begin
      $error("%0d expected action beats never arrived", sched_q.size());
      err_cnt++;
    end

    $display("%0d schedule requests, %0d action beats checked across four handshake mixes",
             n_req, n_beats);
    $display("send %0d recv %0d wait %0d xsend %0d xrecv %0d nothing %0d invalid %0d",
             act_seen[ACT_SEND], act_seen[ACT_RECV], act_seen[ACT_WAIT],
             act_seen[ACT_XSEND], act_seen[ACT_XRECV], act_seen[ACT_NOTHING],
             act_seen[ACT_INVALID]);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bbps_pkg.sv
rtl/core/bbps_req_if.sv
rtl/core/bbps_act_if.sv
rtl/core/bine_broadcast_partner_schedule.sv
verif/tb.sv
